// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } cdq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  typedef struct packed {
    cdq_op_e                  operation;
    logic signed [WordW-1:0]  value;
  } cdq_in_t;

  typedef struct packed {
    cdq_status_e              status;
    logic                     is_empty;
    logic                     is_full;
    logic signed [WordW-1:0]  front_word;
    logic signed [WordW-1:0]  back_word;
  } cdq_out_t;

  // One storage position of the chain: an occupied flag and its word.
  typedef struct packed {
    logic                     valid;
    logic signed [WordW-1:0]  data;
  } cdq_slot_t;

  // Command broadcast to every cell; en is only set for a transaction that is not rejected.
  typedef struct packed {
    logic    en;
    cdq_op_e op;
  } cdq_cmd_t;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// One storage cell of the deque chain, trading words with its two neighbours.
module cdq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::cdq_cmd_t                 cmd_i,
  input  logic signed [cdq_pkg::WordW-1:0]  push_word_i,
  input  cdq_pkg::cdq_slot_t                left_i,
  input  cdq_pkg::cdq_slot_t                right_i,
  output cdq_pkg::cdq_slot_t                slot_o,
  output logic                              last_o
);
  import cdq_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [WordW-1:0] data_q, data_d;

  // Entries are packed from cell 0 (front) upwards; the back is the last occupied cell.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.en) begin
      case (cmd_i.op)
        OP_PUSH_FRONT: begin
          valid_d = left_i.valid;
          data_d  = left_i.data;
        end
        OP_PUSH_BACK: begin
          if (!valid_q && left_i.valid) begin
            valid_d = 1'b1;
            data_d  = push_word_i;
          end
        end
        OP_POP_FRONT: begin
          valid_d = right_i.valid;
          data_d  = right_i.data;
        end
        OP_POP_BACK: begin
          if (valid_q && !right_i.valid) begin
            valid_d = 1'b0;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;
  assign last_o       = valid_q && !right_i.valid;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Top level of the circular deque: a chain of storage cells with a registered result stage.
//
// A double-ended queue of Depth signed 32-bit words. Each input transaction carries
// one operation (push front, push back, pop front, pop back) and a word, and gives
// exactly one output transaction with the status, the empty and full flags and the
// front and back words after the operation (both all ones when empty).
// Both channels use valid and ready. The cell chain is updated at the edge that
// accepts a transaction; the result is then formed from the updated cells and
// loaded into the output register once that register is free.
// Input ready is low while an accepted transaction awaits its result, during which
// the updated chain is read and the back word is gathered across all cells.
// While the receiver stalls, one result waits in the output register and one further
// transaction can be accepted and applied; input ready then stays low until the
// waiting result is taken.
// Reset clears every occupied flag, so the queue starts empty; the stored words are
// not reset and are never shown while unoccupied.
module circular_deque (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdq_pkg::cdq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cdq_pkg::cdq_out_t out_data_o
);
  import cdq_pkg::*;

  cdq_slot_t         slot [Depth];
  logic [Depth-1:0]  slot_valid;
  logic [Depth-1:0]  slot_last;
  cdq_cmd_t          cmd;

  logic              in_fire;
  logic              is_push;
  logic              cur_empty;
  logic              cur_full;
  cdq_status_e       status_now;

  logic              pend_q, pend_d;
  cdq_status_e       pend_status_q, pend_status_d;
  logic              out_valid_q, out_valid_d;
  cdq_out_t          out_q, out_d;
  logic              load_out;
  logic signed [WordW-1:0] back_acc;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cdq_slot_t left_s, right_s;
    if (i == 0) begin : g_first
      assign left_s.valid = 1'b1;
      assign left_s.data  = in_data_i.value;
    end else begin : g_inner_left
      assign left_s = slot[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner_right
      assign right_s = slot[i+1];
    end

    cdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .push_word_i (in_data_i.value),
      .left_i      (left_s),
      .right_i     (right_s),
      .slot_o      (slot[i]),
      .last_o      (slot_last[i])
    );
    assign slot_valid[i] = slot[i].valid;
  end

  assign cur_empty = !slot_valid[0];
  assign cur_full  = slot_valid[Depth-1];
  assign is_push   = (in_data_i.operation == OP_PUSH_FRONT) ||
                     (in_data_i.operation == OP_PUSH_BACK);
  assign in_ready_o = !pend_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    status_now = ST_DONE;
    if (is_push && cur_full) begin
      status_now = ST_FULL;
    end else if (!is_push && cur_empty) begin
      status_now = ST_EMPTY;
    end
  end

  assign cmd.en = in_fire && (status_now == ST_DONE);
  assign cmd.op = in_data_i.operation;

  // Only the last occupied cell passes its word, so an OR over all cells gives the back.
  always_comb begin
    back_acc = '0;
    for (int unsigned i = 0; i < Depth; i++) begin
      back_acc = back_acc | (slot[i].data & {WordW{slot_last[i]}});
    end
  end

  assign load_out = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    pend_d        = pend_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      pend_d           = 1'b0;
      out_valid_d      = 1'b1;
      out_d.status     = pend_status_q;
      out_d.is_empty   = cur_empty;
      out_d.is_full    = cur_full;
      out_d.front_word = cur_empty ? '1 : slot[0].data;
      out_d.back_word  = cur_empty ? '1 : back_acc;
    end
    if (in_fire) begin
      pend_d        = 1'b1;
      pend_status_d = status_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Occupied cells always form one run starting at the front cell.
  a_packed_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((slot_valid & (slot_valid + 1'b1)) == '0))
    else $error("deque cells are not packed from the front");

  // A rejected transaction must leave the occupancy untouched.
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (status_now != ST_DONE)) |=> $stable(slot_valid))
    else $error("rejected transaction changed the deque");

  // A result can never claim to be both empty and full.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_empty && out_data_o.is_full))
    else $error("result flagged empty and full together");
`endif

endmodule

// ===== bench/tb_circular_deque.sv =====
// Self-checking testbench for the circular deque: directed and random operations against a scoreboard.
module tb_circular_deque;
  import cdq_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 1528;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned TailCycles  = 10;
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] AllOnes = {WordW{1'b1}};

  // Keeps its own copy of the deque and the results it should produce, in order.
  class deque_scoreboard;
    logic signed [WordW-1:0] words [Depth];
    int unsigned             head;
    int unsigned             tail;
    bit                      q_empty;
    cdq_out_t                expected_q [$];
    int unsigned             n_errors;

    function new();
      head     = 0;
      tail     = 0;
      q_empty  = 1'b1;
      n_errors = 0;
    endfunction

    function bit full_now();
      return !q_empty && ((tail + 1) % Depth == head);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(cdq_in_t item);
      cdq_out_t res;
      res.status = ST_DONE;
      case (item.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full_now()) begin
            res.status = ST_FULL;
          end else if (q_empty) begin
            // The first entry always lands in position zero.
            head     = 0;
            tail     = 0;
            q_empty  = 1'b0;
            words[0] = item.value;
          end else if (item.operation == OP_PUSH_FRONT) begin
            head        = (head + Depth - 1) % Depth;
            words[head] = item.value;
          end else begin
            tail        = (tail + 1) % Depth;
            words[tail] = item.value;
          end
        end
        default: begin
          if (q_empty) begin
            res.status = ST_EMPTY;
          end else if (head == tail) begin
            head    = 0;
            tail    = 0;
            q_empty = 1'b1;
          end else if (item.operation == OP_POP_FRONT) begin
            head = (head + 1) % Depth;
          end else begin
            tail = (tail + Depth - 1) % Depth;
          end
        end
      endcase
      res.is_empty   = q_empty;
      res.is_full    = full_now();
      res.front_word = q_empty ? AllOnes : words[head];
      res.back_word  = q_empty ? AllOnes : words[tail];
      expected_q.push_back(res);
    endfunction

    function void mismatch(string field, logic [WordW-1:0] exp, logic [WordW-1:0] act);
      n_errors++;
      if (n_errors <= 10) begin
        $display("ERROR: %s expected %h, got %h", field, exp, act);
      end
    endfunction

    function void check_result(cdq_out_t got);
      cdq_out_t exp;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("ERROR: result transaction with nothing outstanding");
        end
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        mismatch("status", exp.status, got.status);
      end
      if (got.is_empty !== exp.is_empty) begin
        mismatch("is_empty", exp.is_empty, got.is_empty);
      end
      if (got.is_full !== exp.is_full) begin
        mismatch("is_full", exp.is_full, got.is_full);
      end
      if (got.front_word !== exp.front_word) begin
        mismatch("front_word", exp.front_word, got.front_word);
      end
      if (got.back_word !== exp.back_word) begin
        mismatch("back_word", exp.back_word, got.back_word);
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  cdq_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  cdq_out_t out_data_o;

  bit              gaps_on = 1'b1;
  deque_scoreboard sb;
  int unsigned     quiet_cycles = 0;
  int unsigned     results_taken = 0;
  int unsigned     hold_left = 0;
  int unsigned     next_hold_at = 400;

  circular_deque uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_op(input cdq_op_e op, input logic signed [WordW-1:0] val);
    cdq_in_t item;
    item.operation = op;
    item.value     = val;
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: random stalls, plus a long hold-off now and then so that the block backs up.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      results_taken++;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (results_taken >= next_hold_at) begin
      out_ready_i  <= 1'b0;
      hold_left    = HoldCycles - 1;
      next_hold_at += 700;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 31);
    end
  end

  // Both handshakes are observed here, so each transaction is noted before its result is checked.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_input(in_data_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cdq_op_e                 op;
    logic signed [WordW-1:0] val;
    int unsigned             mode_left;
    int unsigned             push_pct;
    sb        = new();
    mode_left = 0;
    push_pct  = 50;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on an empty queue, then fill to the top with extreme words from both ends.
    send_op(OP_POP_FRONT, $urandom);
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_PUSH_BACK, WordMax);
    send_op(OP_PUSH_FRONT, WordMin);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, AllOnes);
    send_op(OP_PUSH_BACK, 32'sd1);
    send_op(OP_PUSH_FRONT, 32'sd2);
    send_op(OP_PUSH_BACK, 32'sd3);
    send_op(OP_PUSH_FRONT, 32'sd4);
    send_op(OP_PUSH_BACK, 32'sd5);
    send_op(OP_PUSH_FRONT, 32'sd6);
    // Drain from both ends down to the last entry, which goes from the back.
    repeat (4) send_op(OP_POP_FRONT, $urandom);
    repeat (3) send_op(OP_POP_BACK, $urandom);
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_PUSH_FRONT, 32'sd7);
    send_op(OP_POP_FRONT, $urandom);
    send_op(OP_PUSH_BACK, 32'sd8);
    send_op(OP_POP_BACK, $urandom);

    // Random walks biased towards filling or draining, so full and empty are hit often.
    for (int n = 0; n < RandomItems; n++) begin
      gaps_on <= !(n >= 600 && n < 850);
      if (mode_left == 0) begin
        mode_left = $urandom_range(30, 4);
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      mode_left--;
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       val = WordMin;
          1:       val = WordMax;
          2:       val = '0;
          default: val = AllOnes;
        endcase
      end else begin
        val = $urandom;
      end
      send_op(op, val);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
